// File: hw/rtl/bmm_pkg.sv
package bmm_pkg;

	// Matrix dimension and the index widths that follow from it.
	localparam int DIM   = 16;
	localparam int IDX_W = $clog2(DIM);
	localparam int ADDR_W = 2 * IDX_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	// Request and result field widths.
	localparam int KIND_W    = 2;
	localparam int COORD_W   = 4;
	localparam int VALUE_W   = 8;
	localparam int PRODUCT_W = 20;

	// A single byte product and the running sum over DIM of them.
	localparam int MUL_W = 2 * VALUE_W;
	localparam int ACC_W = MUL_W + IDX_W + 1;

	// Depth of the command queue between front and back.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Request kind codes.
	localparam logic [KIND_W-1:0] KIND_WR_A  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WR_B  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	// Commands handed from the front to the back.
	typedef enum logic [1:0] {
		OP_WR_A,
		OP_WR_B,
		OP_QUERY,
		OP_ZERO
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// File: hw/rtl/bmm_if.sv
interface bmm_req_if;
	logic                                valid;
	logic                                ready;
	logic [bmm_pkg::KIND_W-1:0]          kind;
	logic [bmm_pkg::COORD_W-1:0]         row;
	logic [bmm_pkg::COORD_W-1:0]         col;
	logic signed [bmm_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output kind, output row, output col, output value,
		input ready);
	modport sink (input valid, input kind, input row, input col, input value,
		output ready);
endinterface

interface bmm_res_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [bmm_pkg::PRODUCT_W-1:0] product;

	modport source (output valid, output product, input ready);
	modport sink (input valid, input product, output ready);
endinterface

// File: hw/rtl/byte_matrix_multiply.sv
// Channel   Direction  Fields                        Handshake
// request   in         kind, row, col, value         valid / ready
// result    out        product (20-bit signed)       valid / ready
//
// A write request retires in the back end as soon as it reaches the head of the queue while idle.
// A query performs one multiply-accumulate per cycle, set by the single read port
// of each matrix memory, and passes through read, multiply and sum stages.
// Reset is asynchronous and clears the queue and all control; matrix contents stay undefined.
// Requests keep flowing into the four-entry queue while a result waits to be taken;
// a query starts only when the result register is empty, and ready drops when the queue fills.
module byte_matrix_multiply (
	input  logic       clk,
	input  logic       arst_n,
	bmm_req_if.sink    request,
	bmm_res_if.source  result
);
	import bmm_pkg::*;

	// Commands that passed classification in the front end.
	logic       push;
	cmd_t       push_data;

	// Head of the queue as seen by the back end.
	logic       pop;
	cmd_t       head;
	fifo_stat_t stat;

	// The front end decodes each request: unused kinds and out-of-range writes are
	// dropped, and a query outside the matrix becomes a command that answers zero.
	bmm_front u_front (
		.request   (request),
		.stat      (stat),
		.push      (push),
		.push_data (push_data)
	);

	// A short queue decouples request acceptance from the multiply-accumulate work.
	bmm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.stat      (stat)
	);

	// The back end holds both matrices, performs writes in order with queries, and
	// walks the dot product one element pair per cycle into an accumulator that is saturated on output.
	bmm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.stat   (stat),
		.pop    (pop),
		.result (result)
	);

endmodule

// File: hw/rtl/bmm_front.sv
module bmm_front (
	bmm_req_if.sink              request,
	input  bmm_pkg::fifo_stat_t  stat,
	output logic                 push,
	output bmm_pkg::cmd_t        push_data
);
	import bmm_pkg::*;

	logic in_range;
	logic keep;

	// A request is taken whenever the queue has room; unused kinds and
	// writes outside the matrix are dropped here.
	assign request.ready = !stat.full;
	assign in_range = (int'(request.row) < DIM) && (int'(request.col) < DIM);

	always_comb begin
		keep = 1'b0;
		push_data.op = OP_ZERO;
		unique case (request.kind)
			KIND_WR_A: begin
				keep = in_range;
				push_data.op = OP_WR_A;
			end
			KIND_WR_B: begin
				keep = in_range;
				push_data.op = OP_WR_B;
			end
			KIND_QUERY: begin
				keep = 1'b1;
				push_data.op = in_range ? OP_QUERY : OP_ZERO;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
		push_data.row = IDX_W'(request.row);
		push_data.col = IDX_W'(request.col);
		push_data.value = request.value;
	end

	assign push = request.valid && request.ready && keep;

endmodule

// File: hw/rtl/bmm_fifo.sv
module bmm_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bmm_pkg::cmd_t        push_data,
	input  logic                 pop,
	output bmm_pkg::cmd_t        pop_data,
	output bmm_pkg::fifo_stat_t  stat
);
	import bmm_pkg::*;

	cmd_t                  slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign stat.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hw/rtl/bmm_back.sv
module bmm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bmm_pkg::cmd_t        head,
	input  bmm_pkg::fifo_stat_t  stat,
	output logic                 pop,
	bmm_res_if.source            result
);
	import bmm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	localparam logic [IDX_W-1:0] LAST_K = IDX_W'(DIM - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (PRODUCT_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

	state_t                      state_q;
	logic [IDX_W-1:0]            cnt_q;
	logic [IDX_W-1:0]            row_q;
	logic [IDX_W-1:0]            col_q;
	logic                        out_valid_q;
	logic signed [PRODUCT_W-1:0] out_product_q;

	logic signed [VALUE_W-1:0]   mat_a_q [MEM_DEPTH];
	logic signed [VALUE_W-1:0]   mat_b_q [MEM_DEPTH];

	logic signed [VALUE_W-1:0]   rd_a_s1;
	logic signed [VALUE_W-1:0]   rd_b_s1;
	logic                        valid_s1;
	logic                        first_s1;
	logic                        last_s1;
	logic signed [MUL_W-1:0]     prod_s2;
	logic                        valid_s2;
	logic                        first_s2;
	logic                        last_s2;
	logic signed [ACC_W-1:0]     acc_q;

	logic                        wr_a;
	logic                        wr_b;
	logic                        start;
	logic                        zero;
	logic                        issue;
	logic                        last_k;
	logic                        res_load;
	logic [ADDR_W-1:0]           wr_addr;
	logic [ADDR_W-1:0]           rd_addr_a;
	logic [ADDR_W-1:0]           rd_addr_b;
	logic signed [ACC_W-1:0]     prod_ext;
	logic signed [ACC_W-1:0]     acc_next;
	logic signed [PRODUCT_W-1:0] sat_sum;

	// Writes retire at once while idle; a query or a zero answer waits until the result register is free.
	always_comb begin
		pop = 1'b0;
		wr_a = 1'b0;
		wr_b = 1'b0;
		start = 1'b0;
		zero = 1'b0;
		if (state_q == ST_IDLE && !stat.empty) begin
			unique case (head.op)
				OP_WR_A: begin
					pop = 1'b1;
					wr_a = 1'b1;
				end
				OP_WR_B: begin
					pop = 1'b1;
					wr_b = 1'b1;
				end
				OP_QUERY: begin
					pop = !out_valid_q;
					start = !out_valid_q;
				end
				OP_ZERO: begin
					pop = !out_valid_q;
					zero = !out_valid_q;
				end
				default: begin
					pop = 1'b0;
				end
			endcase
		end
	end

	assign issue = (state_q == ST_ISSUE);
	assign last_k = (cnt_q == LAST_K);
	assign wr_addr = {head.row, head.col};
	assign rd_addr_a = {row_q, cnt_q};
	assign rd_addr_b = {cnt_q, col_q};

	// The result register is loaded by a zero answer or by the last accumulation.
	assign res_load = zero || (state_q == ST_DRAIN && valid_s2 && last_s2);

	assign prod_ext = {{(ACC_W - MUL_W){prod_s2[MUL_W-1]}}, prod_s2};
	assign acc_next = (first_s2 ? '0 : acc_q) + prod_ext;

	always_comb begin
		if (acc_next > SAT_HI) begin
			sat_sum = SAT_HI[PRODUCT_W-1:0];
		end else if (acc_next < SAT_LO) begin
			sat_sum = SAT_LO[PRODUCT_W-1:0];
		end else begin
			sat_sum = acc_next[PRODUCT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			row_q <= '0;
			col_q <= '0;
			out_valid_q <= 1'b0;
			out_product_q <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						row_q <= head.row;
						col_q <= head.col;
						cnt_q <= '0;
						state_q <= ST_ISSUE;
					end else if (zero) begin
						out_product_q <= '0;
					end
				end
				ST_ISSUE: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_k) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (valid_s2 && last_s2) begin
						out_product_q <= sat_sum;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			first_s2 <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			first_s1 <= issue && (cnt_q == '0);
			last_s1 <= issue && last_k;
			valid_s2 <= valid_s1;
			first_s2 <= first_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mat_a_q[wr_addr] <= head.value;
		end
		if (wr_b) begin
			mat_b_q[wr_addr] <= head.value;
		end
		rd_a_s1 <= mat_a_q[rd_addr_a];
		rd_b_s1 <= mat_b_q[rd_addr_b];
		prod_s2 <= rd_a_s1 * rd_b_s1;
		if (valid_s2) begin
			acc_q <= acc_next;
		end
	end

	assign result.valid = out_valid_q;
	assign result.product = out_product_q;

endmodule

// File: hw/rtl/bmm_checker.sv
module bmm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 req_valid,
	input logic                                 req_ready,
	input logic [bmm_pkg::KIND_W-1:0]           req_kind,
	input logic                                 res_valid,
	input logic                                 res_ready,
	input logic signed [bmm_pkg::PRODUCT_W-1:0] res_product
);
	import bmm_pkg::*;

	localparam int PEND_MAX = FIFO_DEPTH + 2;
	localparam int PEND_W = $clog2(PEND_MAX + 2);

	logic [PEND_W-1:0] pend_q;
	logic              inc;
	logic              dec;

	assign inc = req_valid && req_ready && (req_kind == KIND_QUERY);
	assign dec = res_valid && res_ready;

	// Queries accepted but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (inc && !dec) begin
			pend_q <= pend_q + 1'b1;
		end else if (dec && !inc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_product))
		else $error("result dropped or changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != '0)
		else $error("result shown with no query outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(PEND_MAX))
		else $error("more queries outstanding than the block can hold");

endmodule

bind byte_matrix_multiply bmm_checker u_bmm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (request.valid),
	.req_ready   (request.ready),
	.req_kind    (request.kind),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_product (result.product)
);

// File: sim/tb_byte_matrix_multiply.sv
`timescale 1ns / 100ps

module tb_byte_matrix_multiply;

	import bmm_pkg::*;

	// Kind 3 has no meaning in the block; it must be swallowed without a result.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 9;
	localparam int COORD_SPAN   = 1 << COORD_W;

	// The product field saturates at its signed 20-bit limits when DIM is large.
	localparam int PRODUCT_MAX = (1 << (PRODUCT_W - 1)) - 1;
	localparam int PRODUCT_MIN = -(1 << (PRODUCT_W - 1));

	// The drain adds some margin after the last result for a write still sitting in the queue.
	localparam int DRAIN_CYCLES = DIM + 16;

	// Slowest legal stretch without any handshake: a long sender gap or a long result
	// stall on top of a query still computing. The limit below is that stretch taken
	// many times over.
	localparam int STALL_LIMIT = 3000;

	localparam int RANDOM_ITEMS = 650;

	logic clk = 1'b0;
	logic arst_n;

	bmm_req_if request_ch ();
	bmm_res_if result_ch ();

	byte_matrix_multiply u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request_ch),
		.result (result_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow copy of both matrices, plus a record of which entries were written.
	// A query is only sent once every entry it reads has been written.
	logic signed [VALUE_W-1:0] mat_a [COORD_SPAN][COORD_SPAN];
	logic signed [VALUE_W-1:0] mat_b [COORD_SPAN][COORD_SPAN];
	bit                        a_loaded [COORD_SPAN][COORD_SPAN];
	bit                        b_loaded [COORD_SPAN][COORD_SPAN];

	// Products owed by the block, oldest first.
	logic signed [PRODUCT_W-1:0] expected_products [$];

	int writes_sent;
	int queries_sent;
	int ignored_sent;
	int products_checked;
	int mismatch_count;
	int idle_cycles;

	// Idling switches for the request side and the result side.
	bit src_idle_on;
	bit snk_idle_on;

	logic signed [PRODUCT_W-1:0] wanted_product;

	// Mostly back-to-back, sometimes a few cycles, now and then a long pause.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Element values lean toward the extremes so that large sums show up often.
	function automatic logic signed [VALUE_W-1:0] random_byte();
		int roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: return -128;
			1: return 127;
			2: return 0;
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	// C[row][col] as the block must report it: exact sum, clipped to the field range.
	// Coordinates outside the matrix yield zero.
	function automatic logic signed [PRODUCT_W-1:0] dot_product(
		input logic [COORD_W-1:0] row,
		input logic [COORD_W-1:0] col
	);
		int acc;
		acc = 0;
		if (row < DIM && col < DIM) begin
			for (int k = 0; k < DIM; k++)
				acc += int'(mat_a[row][k]) * int'(mat_b[k][col]);
		end
		if (acc > PRODUCT_MAX)
			acc = PRODUCT_MAX;
		if (acc < PRODUCT_MIN)
			acc = PRODUCT_MIN;
		return acc[PRODUCT_W-1:0];
	endfunction

	task automatic report_mismatch(
		input string                       what,
		input logic signed [PRODUCT_W-1:0] got,
		input logic signed [PRODUCT_W-1:0] want
	);
		mismatch_count++;
		$display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Sends one request. Valid is left high on return so that a following request
	// with no gap goes out on the very next cycle; the shadow matrices and the
	// list of owed products are updated at the edge where the request is taken.
	task automatic send_request(
		input logic [KIND_W-1:0]         kind,
		input logic [COORD_W-1:0]        row,
		input logic [COORD_W-1:0]        col,
		input logic signed [VALUE_W-1:0] value
	);
		int gap;
		gap = src_idle_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			// Idle with junk on the payload; the block must ignore it.
			request_ch.valid <= 1'b0;
			request_ch.kind  <= KIND_W'($urandom);
			request_ch.row   <= COORD_W'($urandom);
			request_ch.col   <= COORD_W'($urandom);
			request_ch.value <= VALUE_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.kind  <= kind;
		request_ch.row   <= row;
		request_ch.col   <= col;
		request_ch.value <= value;
		do
			@(posedge clk);
		while (!request_ch.ready);

		case (kind)
			KIND_WR_A: begin
				writes_sent++;
				if (row < DIM && col < DIM) begin
					mat_a[row][col]    = value;
					a_loaded[row][col] = 1'b1;
				end
			end
			KIND_WR_B: begin
				writes_sent++;
				if (row < DIM && col < DIM) begin
					mat_b[row][col]    = value;
					b_loaded[row][col] = 1'b1;
				end
			end
			KIND_QUERY: begin
				queries_sent++;
				expected_products.push_back(dot_product(row, col));
			end
			default: ignored_sent++;
		endcase
	endtask

	// Writes a whole row of A, either with one fill value or with random bytes.
	task automatic load_row_a(input int row, input bit use_fill,
		input logic signed [VALUE_W-1:0] fill);
		for (int k = 0; k < DIM; k++)
			send_request(KIND_WR_A, COORD_W'(row), COORD_W'(k),
				use_fill ? fill : random_byte());
	endtask

	task automatic load_col_b(input int col, input bit use_fill,
		input logic signed [VALUE_W-1:0] fill);
		for (int k = 0; k < DIM; k++)
			send_request(KIND_WR_B, COORD_W'(k), COORD_W'(col),
				use_fill ? fill : random_byte());
	endtask

	// Queries C[row][col], first writing whatever part of the row of A or the column
	// of B has never been written, so that no undefined entry is ever read.
	task automatic query_element(input int row, input int col);
		for (int k = 0; k < DIM; k++) begin
			if (row < DIM && !a_loaded[row][k])
				send_request(KIND_WR_A, COORD_W'(row), COORD_W'(k), random_byte());
		end
		for (int k = 0; k < DIM; k++) begin
			if (col < DIM && !b_loaded[k][col])
				send_request(KIND_WR_B, COORD_W'(k), COORD_W'(col), random_byte());
		end
		send_request(KIND_QUERY, COORD_W'(row), COORD_W'(col), VALUE_W'($urandom));
	endtask

	// Corner coordinates with extreme values, and kind 3 requests aimed at cells
	// that are read afterward: if the block wrote them, the products would show it.
	task automatic test_corner_requests();
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		send_request(KIND_WR_A, 0, 0, -128);
		send_request(KIND_WR_A, 15, 15, 127);
		send_request(KIND_WR_A, 0, 15, -1);
		send_request(KIND_WR_A, 15, 0, 1);
		send_request(KIND_WR_B, 0, 0, 127);
		send_request(KIND_WR_B, 15, 15, -128);
		send_request(KIND_WR_B, 15, 0, 0);
		send_request(KIND_WR_B, 0, 15, 8'h55);
		send_request(KIND_UNUSED, 0, 0, 127);
		send_request(KIND_UNUSED, 15, 15, -128);
		send_request(KIND_UNUSED, 15, 0, 8'hAA);
		query_element(0, 0);
		query_element(15, 15);
		query_element(0, 15);
		query_element(15, 0);
		// A query's value field carries no meaning; try both extremes there.
		send_request(KIND_QUERY, 0, 0, -128);
		send_request(KIND_QUERY, 15, 15, 127);
	endtask

	// Full rows and columns of one value reach the largest and smallest sums and zero.
	task automatic test_extreme_sums();
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		load_row_a(3, 1'b1, -128);
		load_col_b(5, 1'b1, -128);
		send_request(KIND_QUERY, 3, 5, 0);
		load_col_b(5, 1'b1, 127);
		send_request(KIND_QUERY, 3, 5, 0);
		load_row_a(3, 1'b1, 127);
		send_request(KIND_QUERY, 3, 5, 0);
		load_row_a(3, 1'b1, 0);
		send_request(KIND_QUERY, 3, 5, 0);
		load_row_a(12, 1'b1, 127);
		load_col_b(9, 1'b1, -128);
		send_request(KIND_QUERY, 12, 9, 0);
	endtask

	// Queries back to back fill the request queue, first against a result side that
	// stalls, then against one that is always ready. Writes to random cells land between
	// queries that may read them, so request order inside the block is exercised.
	task automatic test_query_burst();
		src_idle_on = 1'b0;
		snk_idle_on = 1'b1;
		for (int n = 0; n < 60; n++) begin
			query_element($urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1));
			if (n % 4 == 3)
				send_request(KIND_WR_A, COORD_W'($urandom), COORD_W'($urandom),
					random_byte());
		end
		snk_idle_on = 1'b0;
		for (int n = 0; n < 40; n++) begin
			query_element($urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1));
			if (n % 3 == 2)
				send_request(KIND_WR_B, COORD_W'($urandom), COORD_W'($urandom),
					random_byte());
		end
	endtask

	// Mostly well-formed traffic: row and column loads, single writes and queries,
	// with some kind 3 noise. Every few hundred requests both sides run without
	// idling for a while.
	task automatic test_random_traffic();
		int roll;
		int start_count;
		int done;
		start_count = writes_sent + queries_sent;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			src_idle_on = (done % 300) >= 50;
			snk_idle_on = (done % 300) >= 50;
			roll = $urandom_range(0, 99);
			if (roll < 8)
				load_row_a($urandom_range(0, DIM - 1), 1'b0, 0);
			else if (roll < 16)
				load_col_b($urandom_range(0, DIM - 1), 1'b0, 0);
			else if (roll < 50)
				send_request($urandom_range(0, 1) ? KIND_WR_B : KIND_WR_A,
					COORD_W'($urandom), COORD_W'($urandom), random_byte());
			else if (roll < 55)
				send_request(KIND_UNUSED, COORD_W'($urandom), COORD_W'($urandom),
					VALUE_W'($urandom));
			else
				query_element($urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1));
			done = writes_sent + queries_sent - start_count;
		end
	endtask

	// Result side: ready is held high, with random stalls while idling is enabled.
	initial begin
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (snk_idle_on && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat (1 + pick_gap()) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	// Every product taken is compared with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_products.size() == 0) begin
				report_mismatch("product with no query pending", result_ch.product, 0);
			end else begin
				wanted_product = expected_products.pop_front();
				products_checked++;
				if (result_ch.product !== wanted_product)
					report_mismatch("product", result_ch.product, wanted_product);
			end
		end
	end

	// The run is cut short if neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d products still owed",
					$realtime, STALL_LIMIT, expected_products.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		request_ch.valid = 1'b0;
		request_ch.kind  = KIND_WR_A;
		request_ch.row   = '0;
		request_ch.col   = '0;
		request_ch.value = '0;
		idle_cycles      = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_corner_requests();
		test_extreme_sums();
		test_query_burst();
		test_random_traffic();

		@(negedge clk);
		request_ch.valid <= 1'b0;
		while (expected_products.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d element writes, %0d product queries, %0d kind 3 requests.",
			writes_sent, queries_sent, ignored_sent);
		$display("Checked %0d products; %0d mismatches.", products_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
